[hw/rtl/ffea_pkg.sv]
package ffea_pkg;

   localparam int MaxExtentsDefault = 16;
   localparam int AddrWidth = 48;
   localparam int ExtWidth = 49;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_OVERLAP = 2'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_BYTES = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_PUT,
      ST_DONE,
      ST_REBUILD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;     // capture request
      logic rd_cur;       // read entry at cursor
      logic cur_inc;      // advance cursor
      logic set_cur_last; // cursor to count-1 for shift up
      logic cur_dec;
      logic trim;         // alloc trim current
      logic set_start;    // free merge down
      logic set_end;      // free merge up
      logic move_up;      // entry[cur+1] = entry[cur]
      logic move_down;    // entry[cur] = entry[cur+1]
      logic put;          // entry[pos] = block
      logic cnt_inc;
      logic cnt_dec;
      logic rebuild;
      logic set_status;
      logic [1:0] status;
      logic grant;        // latch grant from current
      logic save_pos;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_free;
      logic walk_end;     // cursor reached count
      logic full;
      logic sz_eq;
      logic sz_gt;
      logic st_gt;        // start > blk_end
      logic st_eq;        // start == blk_end
      logic en_eq;        // end == addr
      logic en_lt;        // end < addr
      logic up_done;      // cursor below saved pos during shift up
      logic down_done;    // cursor+1 reached count
   } sts_type;

endpackage

[hw/rtl/ffea_ctrl.sv]
module ffea_ctrl
   import ffea_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    cfg_write,
   input  logic    rsp_taken,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    done
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_REBUILD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cfg_write) begin
               state_in = ST_REBUILD;
            end else if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (sts.walk_end) begin
               if (sts.is_free && !sts.full) begin
                  state_in = ST_SHIFT_UP;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (!sts.is_free) begin
               if (sts.sz_eq) begin
                  state_in = ST_SHIFT_DOWN;
               end else if (sts.sz_gt) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               if (sts.st_gt) begin
                  state_in = sts.full ? ST_DONE : ST_SHIFT_UP;
               end else if (sts.st_eq || sts.en_eq || !sts.en_lt) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SHIFT_UP: state_in = sts.up_done ? ST_PUT : ST_SHIFT_UP;
         ST_PUT: state_in = ST_DONE;
         ST_SHIFT_DOWN: state_in = sts.down_done ? ST_DONE : ST_SHIFT_DOWN;
         ST_DONE: begin
            if (rsp_taken) begin
               state_in = ST_IDLE;
            end
         end
         ST_REBUILD: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load_req = start && !cfg_write;
         end
         ST_READ: cmd.rd_cur = 1'b1;
         ST_EVAL: begin
            cmd.set_status = 1'b1;
            cmd.status = STATUS_OK;
            if (sts.walk_end) begin
               if (!sts.is_free) begin
                  cmd.status = STATUS_NO_FIT;
               end else if (sts.full) begin
                  cmd.status = STATUS_FULL;
               end else begin
                  cmd.save_pos = 1'b1;
                  cmd.set_cur_last = 1'b1;
               end
            end else if (!sts.is_free) begin
               if (sts.sz_eq) begin
                  cmd.grant = 1'b1;
               end else if (sts.sz_gt) begin
                  cmd.grant = 1'b1;
                  cmd.trim = 1'b1;
               end else begin
                  cmd.set_status = 1'b0;
                  cmd.cur_inc = 1'b1;
               end
            end else begin
               if (sts.st_gt) begin
                  if (sts.full) begin
                     cmd.status = STATUS_FULL;
                  end else begin
                     cmd.save_pos = 1'b1;
                     cmd.set_cur_last = 1'b1;
                  end
               end else if (sts.st_eq) begin
                  cmd.set_start = 1'b1;
               end else if (sts.en_eq) begin
                  cmd.set_end = 1'b1;
               end else if (sts.en_lt) begin
                  cmd.set_status = 1'b0;
                  cmd.cur_inc = 1'b1;
               end else begin
                  cmd.status = STATUS_OVERLAP;
               end
            end
         end
         ST_SHIFT_UP: begin
            if (!sts.up_done) begin
               cmd.move_up = 1'b1;
               cmd.cur_dec = 1'b1;
            end
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_SHIFT_DOWN: begin
            if (sts.down_done) begin
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.move_down = 1'b1;
               cmd.cur_inc = 1'b1;
            end
         end
         ST_DONE: done = 1'b1;
         ST_REBUILD: cmd.rebuild = 1'b1;
         default: ;
      endcase
   end

endmodule

[hw/rtl/ffea_dpath.sv]
module ffea_dpath
   import ffea_pkg::*;
#(
   parameter int MAX_EXTENTS = MaxExtentsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic                 req_mode,
   input  logic [AddrWidth-1:0] req_addr,
   input  logic [AddrWidth-1:0] req_bytes,
   input  logic [AddrWidth-1:0] region_base,
   input  logic [AddrWidth-1:0] region_bytes,
   output sts_type              sts,
   output logic [AddrWidth-1:0] grant_addr,
   output logic [1:0]           status
);

   localparam int IdxW = $clog2(MAX_EXTENTS);
   localparam int CntW = $clog2(MAX_EXTENTS + 1);

   // start and end packed into one word per entry
   logic [2*ExtWidth-1:0] mem [MAX_EXTENTS];

   logic [CntW-1:0]      count_ff, cur_ff, pos_ff;
   logic                 mode_ff;
   logic [AddrWidth-1:0] addr_ff, bytes_ff, grant_ff;
   logic [ExtWidth-1:0]  blk_end_ff;
   logic [1:0]           status_ff;
   logic [ExtWidth-1:0]  rd_start, rd_end;

   logic [ExtWidth-1:0]  size;
   logic [ExtWidth-1:0]  want;
   logic [ExtWidth-1:0]  addr_x;
   logic [CntW-1:0]      cur_nx;

   assign want   = {1'b0, bytes_ff};
   assign addr_x = {1'b0, addr_ff};
   assign size   = rd_end - rd_start;
   assign cur_nx = cur_ff + CntW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CntW'(1);
         cur_ff <= '0;
      end else begin
         if (cmd.rebuild) begin
            count_ff <= CntW'(1);
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + CntW'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CntW'(1);
         end
         if (cmd.load_req) begin
            cur_ff <= '0;
         end else if (cmd.set_cur_last) begin
            cur_ff <= count_ff - CntW'(1);
         end else if (cmd.cur_inc) begin
            cur_ff <= cur_nx;
         end else if (cmd.cur_dec) begin
            cur_ff <= cur_ff - CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         addr_ff <= req_addr;
         bytes_ff <= req_bytes;
         blk_end_ff <= {1'b0, req_addr} + {1'b0, req_bytes};
         grant_ff <= '0;
      end
      if (cmd.save_pos) begin
         pos_ff <= cur_ff;
      end
      if (cmd.grant) begin
         grant_ff <= rd_start[AddrWidth-1:0];
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.rebuild) begin
         mem[0] <= {{1'b0, region_base}, {1'b0, region_base} + {1'b0, region_bytes}};
      end else if (cmd.trim) begin
         mem[cur_ff[IdxW-1:0]] <= {rd_start + want, rd_end};
      end else if (cmd.set_start) begin
         mem[cur_ff[IdxW-1:0]] <= {addr_x, rd_end};
      end else if (cmd.set_end) begin
         mem[cur_ff[IdxW-1:0]] <= {rd_start, blk_end_ff};
      end else if (cmd.move_up) begin
         mem[cur_nx[IdxW-1:0]] <= {rd_start, rd_end};
      end else if (cmd.move_down) begin
         mem[cur_ff[IdxW-1:0]] <= {rd_start, rd_end};
      end else if (cmd.put) begin
         mem[pos_ff[IdxW-1:0]] <= {addr_x, blk_end_ff};
      end
   end

   // read address: shift down reads the next entry, shift up the current one
   logic [CntW-1:0] rd_idx;
   logic            rd_en;
   always_comb begin
      rd_idx = cur_ff;
      if (cmd.move_down) begin
         rd_idx = cur_nx + CntW'(1);
      end else if (cmd.grant && !cmd.trim) begin
         // exact fit: the first shift step needs entry cur+1 already loaded
         rd_idx = cur_nx;
      end else if (cmd.cur_dec) begin
         rd_idx = cur_ff - CntW'(1);
      end else if (cmd.set_cur_last) begin
         rd_idx = count_ff - CntW'(1);
      end else if (cmd.cur_inc && !cmd.rd_cur) begin
         rd_idx = cur_nx + CntW'(1);
      end
      rd_en = 1'b1;
   end

   logic [2*ExtWidth-1:0] rd_word;
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word <= mem[rd_idx[IdxW-1:0]];
      end
   end

   always_comb begin
      rd_start = rd_word[2*ExtWidth-1:ExtWidth];
      rd_end   = rd_word[ExtWidth-1:0];
   end

   always_comb begin
      sts.is_free   = (mode_ff == MODE_FREE);
      sts.walk_end  = (cur_ff >= count_ff);
      sts.full      = (count_ff >= CntW'(MAX_EXTENTS));
      sts.sz_eq     = (size == want);
      sts.sz_gt     = (size > want);
      sts.st_gt     = (rd_start > blk_end_ff);
      sts.st_eq     = (rd_start == blk_end_ff);
      sts.en_eq     = (rd_end == addr_x);
      sts.en_lt     = (rd_end < addr_x);
      sts.up_done   = (cur_ff < pos_ff) || (cur_ff == pos_ff - CntW'(1))
                      || (count_ff == '0) || (cur_ff >= count_ff);
      sts.down_done = (cur_nx >= count_ff);
   end

   assign grant_addr = grant_ff;
   assign status = status_ff;

endmodule

[hw/rtl/first_fit_extent_allocator_top.sv]
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tuser: mode; tdata: block_address, block_bytes
// rsp_      out  rsp_tvalid/rsp_tready  tdata: granted_address, status
// csr_      in   csr_we                 index 0 region_base, 1 region_bytes
//
// One item at a time: an allocate walks the table entry by entry, and on an exact
// fit shifts the later entries down to close the gap; a free walks to its place
// and, if it cannot merge, shifts later entries up to open a slot and places the
// block. The next request is taken only after the walk and the response transfer.
// Reset (synchronous) enters a rebuild state that reloads the table from the region
// registers. A stalled response holds in the output register; the next request
// waits until it transfers.
module first_fit_extent_allocator_top
   import ffea_pkg::*;
#(
   parameter int MAX_EXTENTS = MaxExtentsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // mode
   input  logic [95:0]  req_tdata,   // block_address[47:0], block_bytes[95:48]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // granted_address[47:0], status[49:48], zero
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata
);

   logic [AddrWidth-1:0] base_ff, bytes_ff;
   cmd_type cmd;
   sts_type sts;
   logic busy, done;
   logic [AddrWidth-1:0] grant;
   logic [1:0] status;

   // hold region registers; a write rebuilds the table when it lands while the controller is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         bytes_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == REG_BASE) begin
            base_ff <= csr_wdata;
         end else begin
            bytes_ff <= csr_wdata;
         end
      end
   end

   logic cfg_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_pend_ff <= 1'b0;
      end else begin
         cfg_pend_ff <= csr_we;
      end
   end

   assign req_tready = !busy && !cfg_pend_ff && !csr_we;

   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && req_tready),
      .cfg_write (cfg_pend_ff),
      .rsp_taken (rsp_tready),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .done      (done)
   );

   ffea_dpath #(.MAX_EXTENTS(MAX_EXTENTS)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_mode     (req_tuser),
      .req_addr     (req_tdata[47:0]),
      .req_bytes    (req_tdata[95:48]),
      .region_base  (base_ff),
      .region_bytes (bytes_ff),
      .sts          (sts),
      .grant_addr   (grant),
      .status       (status)
   );

   assign rsp_tvalid = done;
   assign rsp_tdata = {6'd0, status, grant};

   // a response never shows while a request is being taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("response and request overlap");

   // a request transfer is followed by busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> busy)
      else $error("not busy after request");

endmodule

[sim/first_fit_extent_allocator_checker.sv]
module first_fit_extent_allocator_checker
   import ffea_pkg::*;
#(
   parameter int MAX_EXTENTS = MaxExtentsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,
   input  logic [95:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           allocs_seen,
   output int           frees_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // status in the upper bits, matching the result tdata layout
   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] granted;
   } grant_type;

   logic [47:0] base_q, bytes_q;
   logic [48:0] ext_lo [MAX_EXTENTS];
   logic [48:0] ext_hi [MAX_EXTENTS];
   int          ext_num;
   grant_type   grant_q [$];

   function automatic void rebuild_extents();
      for (int i = 0; i < MAX_EXTENTS; i++) begin
         ext_lo[i] = '0;
         ext_hi[i] = '0;
      end
      ext_lo[0] = {1'b0, base_q};
      ext_hi[0] = {1'b0, base_q} + {1'b0, bytes_q};
      ext_num = 1;
   endfunction

   function automatic void remove_extent(int idx);
      for (int i = idx; i + 1 < ext_num; i++) begin
         ext_lo[i] = ext_lo[i + 1];
         ext_hi[i] = ext_hi[i + 1];
      end
      ext_num--;
   endfunction

   function automatic void insert_extent(int idx, logic [48:0] lo, logic [48:0] hi);
      for (int i = ext_num; i > idx; i--) begin
         ext_lo[i] = ext_lo[i - 1];
         ext_hi[i] = ext_hi[i - 1];
      end
      ext_lo[idx] = lo;
      ext_hi[idx] = hi;
      ext_num++;
   endfunction

   function automatic grant_type predict_alloc(logic [47:0] want);
      grant_type r;
      logic [48:0] sz;
      r = '{granted: '0, status: STATUS_NO_FIT};
      for (int i = 0; i < ext_num; i++) begin
         sz = ext_hi[i] - ext_lo[i];
         if (sz == {1'b0, want}) begin
            r = '{granted: ext_lo[i][47:0], status: STATUS_OK};
            remove_extent(i);
            return r;
         end
         if (sz > {1'b0, want}) begin
            r = '{granted: ext_lo[i][47:0], status: STATUS_OK};
            ext_lo[i] = ext_lo[i] + {1'b0, want};
            return r;
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] predict_free(logic [47:0] addr, logic [47:0] len);
      logic [48:0] a, e;
      a = {1'b0, addr};
      e = a + {1'b0, len};
      for (int i = 0; i < ext_num; i++) begin
         if (ext_lo[i] > e) begin
            if (ext_num >= MAX_EXTENTS) return STATUS_FULL;
            insert_extent(i, a, e);
            return STATUS_OK;
         end else if (ext_lo[i] == e) begin
            ext_lo[i] = a;
            return STATUS_OK;
         end else if (ext_hi[i] == a) begin
            ext_hi[i] = e;
            return STATUS_OK;
         end else if (ext_hi[i] < a) begin
            continue;
         end else begin
            return STATUS_OVERLAP;
         end
      end
      if (ext_num >= MAX_EXTENTS) return STATUS_FULL;
      insert_extent(ext_num, a, e);
      return STATUS_OK;
   endfunction

   always @(posedge clock) begin
      grant_type exp_r, got;
      int errs;
      errs = 0;
      if (reset) begin
         base_q = '0;
         bytes_q = '0;
         rebuild_extents();
         grant_q.delete();
         fail_count <= 0;
         allocs_seen <= 0;
         frees_seen <= 0;
      end else begin
         // check the result side first; a request can't complete in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[49:0];
            if (grant_q.size() == 0) begin
               $error("unexpected result transfer %h", rsp_tdata);
               errs++;
            end else begin
               exp_r = grant_q.pop_front();
               if (got.granted !== exp_r.granted) begin
                  $error("granted_address expected %h actual %h",
                         exp_r.granted, got.granted);
                  errs++;
               end
               if (got.status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, got.status);
                  errs++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == REG_BASE) base_q = csr_wdata;
            else bytes_q = csr_wdata;
            rebuild_extents();
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_ALLOC) begin
               exp_r = predict_alloc(req_tdata[95:48]);
               allocs_seen <= allocs_seen + 1;
            end else begin
               exp_r = '{granted: '0,
                         status: predict_free(req_tdata[47:0], req_tdata[95:48])};
               frees_seen <= frees_seen + 1;
            end
            grant_q.push_back(exp_r);
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= grant_q.size();
   end
endmodule

[sim/first_fit_extent_allocator_top_tb.sv]
module first_fit_extent_allocator_top_tb
   import ffea_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 4 + 3 * MaxExtentsDefault + 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser = 1'b0;  // mode
   logic [95:0]  req_tdata = '0;    // block_address[47:0], block_bytes[95:48]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;         // granted_address[47:0], status[49:48], zero
   logic         csr_we = 1'b0;
   logic         csr_index = REG_BASE;
   logic [47:0]  csr_wdata = '0;
   int           fail_count, pending_count, allocs_seen, frees_seen;

   // recent grants, so frees can hand back real blocks
   logic [47:0]  held_addr [$];
   logic [47:0]  held_len [$];
   logic [47:0]  cur_base, cur_bytes;

   always #4 clock = ~clock;

   first_fit_extent_allocator_top dut (.*);

   first_fit_extent_allocator_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .allocs_seen, .frees_seen);

   // receiver: stall on a pattern that changes mode every so often
   initial begin
      int stall_mode;
      int left;
      stall_mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            stall_mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
         end
         left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // remember what the block granted, for later frees
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready && req_tuser == MODE_ALLOC
          && held_addr.size() < 64) begin
         held_len.push_back(req_tdata[95:48]);
      end
   end

   // burst sender: hold valid through a burst, drop it for a random gap between bursts
   int burst_left = 0;

   task automatic send(logic mode, logic [47:0] addr, logic [47:0] len);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {len, addr};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [47:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_BASE) cur_base = val;
      else cur_bytes = val;
      held_addr.delete();
      held_len.delete();
      @(negedge clock);
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[63:16];
   endfunction

   // an address from the region base up to its end, wrapping past the top of the 48-bit space
   function automatic logic [47:0] in_region();
      logic [48:0] span, off;
      span = {1'b0, cur_bytes} + 49'd1;
      off = {1'b0, rand48()} % span;
      return cur_base + off[47:0];
   endfunction

   // a size that usually fits, scaled to the region
   function automatic logic [47:0] pick_size();
      case ($urandom_range(0, 9))
         0: return 48'd0;
         1: return rand48();
         2: return cur_bytes >> $urandom_range(0, 4);
         default: return (cur_bytes >> $urandom_range(3, 8)) + 48'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic random_phase(int count);
      int pick;
      logic [47:0] a, l;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            send(MODE_ALLOC, rand48(), pick_size());
         end else if (pick < 8 && held_addr.size() > 0) begin
            // free part or all of a granted block, sometimes twice (overlap)
            pick = $urandom_range(0, held_addr.size() - 1);
            a = held_addr[pick];
            l = held_len[pick];
            if ($urandom_range(0, 3) != 0) begin
               held_addr.delete(pick);
               held_len.delete(pick);
            end
            if (l > 2 && $urandom_range(0, 2) == 0) begin
               // fragment: free only the tail, building up the table
               a = a + l / 2;
               l = l - l / 2;
            end
            send(MODE_FREE, a, l);
         end else begin
            send(MODE_FREE, ($urandom_range(0, 1) != 0) ? rand48() : in_region(),
                 ($urandom_range(0, 1) != 0) ? rand48() : 48'($urandom_range(0, 64)));
         end
      end
   endtask

   // pick up granted addresses as results transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && held_len.size() > held_addr.size()) begin
         if (rsp_tdata[49:48] == STATUS_OK) held_addr.push_back(rsp_tdata[47:0]);
         else held_len.delete(held_addr.size());
      end
   end

   initial begin
      #5ms;
      $display("first_fit_extent_allocator_top_tb NOT OK");
      $finish;
   end

   initial begin
      cur_base = '0;
      cur_bytes = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty region after reset: zero-size exact fit removes it, then empty table
      send(MODE_ALLOC, '0, '0);
      send(MODE_ALLOC, '0, 48'd1);
      send(MODE_FREE, 48'd100, 48'd10);
      send(MODE_FREE, 48'd110, 48'd5);   // merge after
      send(MODE_FREE, 48'd90, 48'd10);   // merge before
      send(MODE_FREE, 48'd95, 48'd2);    // overlap
      send(MODE_ALLOC, '0, 48'd25);      // exact fit
      settle();

      // top of the address space: high grant above 2^48
      write_reg(REG_BASE, 48'hFFFF_FFFF_FFF0);
      write_reg(REG_BYTES, 48'hFFFF_FFFF_FFFF);
      send(MODE_ALLOC, '0, 48'h20);
      send(MODE_ALLOC, '0, 48'h10);
      send(MODE_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send(MODE_ALLOC, '0, '0);
      send(MODE_FREE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      settle();

      // fill the table with isolated frees until full
      write_reg(REG_BASE, 48'd1000);
      write_reg(REG_BYTES, 48'd10);
      for (int i = 0; i < 17; i++) send(MODE_FREE, 48'd10 * i, 48'd3);
      send(MODE_FREE, 48'd23, 48'd2);    // merge while full
      send(MODE_ALLOC, '0, 48'd2);
      send(MODE_ALLOC, '0, 48'd100);     // no fit
      settle();

      // random phases over several region settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_reg(REG_BASE, 48'd0); write_reg(REG_BYTES, 48'h1_0000); end
            1: begin write_reg(REG_BYTES, 48'hFFFF_FFFF_FFFF); end
            2: begin write_reg(REG_BASE, 48'hFFFF_FFFF_FFFF); end
            3: begin write_reg(REG_BASE, rand48()); write_reg(REG_BYTES, 48'd4096); end
            4: begin write_reg(REG_BYTES, 48'd0); end
            5: begin write_reg(REG_BASE, 48'h8000_0000_0000); write_reg(REG_BYTES, 48'd300); end
            default: begin write_reg(REG_BASE, rand48()); write_reg(REG_BYTES, rand48()); end
         endcase
         random_phase(200);
         settle();
      end

      $display("covered %0d allocates and %0d frees over directed and random region settings",
               allocs_seen, frees_seen);
      if (fail_count == 0) begin
         $display("first_fit_extent_allocator_top_tb OK");
      end else begin
         $display("first_fit_extent_allocator_top_tb NOT OK");
      end
      $finish;
   end
endmodule
